// File: design/ptsp_pkg.sv
// ---------------------------------------------------------------------------
// ptsp_pkg
// Shared types and constants of the PES to transport stream packetizer.
// ---------------------------------------------------------------------------
package ptsp_pkg;

   localparam int PACKET_BYTES = 188;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   localparam logic [7:0] CSR_FIRST_PID  = 8'd0;
   localparam logic [7:0] CSR_PCR_STREAM = 8'd1;
   localparam logic [7:0] CSR_VIDEO_MASK = 8'd2;
   localparam logic [7:0] CSR_H265_MASK  = 8'd3;

   typedef struct packed {
      logic        kind;
      logic [2:0]  stream_index;
      logic [23:0] frame_length;
      logic [32:0] pts;
      logic [32:0] dts;
      logic        has_delimiter;
      logic        is_keyframe;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] packet_word;
      logic [3:0]  byte_count;
      logic        packet_end;
   } rsp_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  idx;
      logic [23:0] len;
      logic [32:0] pts;
      logic [32:0] dts;
      logic        video;
      logic        h265;
      logic        pcr;
      logic        key;
      logic        delim;
      logic [7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // five-byte pes timestamp with marker bits
   function automatic logic [39:0] pes_stamp(input logic [3:0] prefix, input logic [32:0] ts);
      pes_stamp = {prefix, ts[32:30], 1'b1, ts[29:22], ts[21:15], 1'b1,
                   ts[14:7], ts[6:0], 1'b1};
   endfunction

endpackage

// File: design/ptsp_front.sv
// ---------------------------------------------------------------------------
// ptsp_front
// Accepts items, filters them against the open frame and queues commands.
// ---------------------------------------------------------------------------
module ptsp_front #(
   parameter int NUM_STREAMS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ptsp_pkg::req_type      req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_index,
   input  logic [15:0]            csr_data,
   output logic                   push,
   output ptsp_pkg::cmd_type      cmd,
   input  ptsp_pkg::q_status_type q_status,
   output logic [12:0]            first_pid
);
   import ptsp_pkg::*;

   logic [12:0] first_pid_ff;
   logic [2:0]  pcr_stream_ff;
   logic [7:0]  video_mask_ff;
   logic [7:0]  h265_mask_ff;
   logic [23:0] bytes_left_ff, bytes_left_in;
   logic        accept;
   logic        frame_ok;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign first_pid = first_pid_ff;

   assign frame_ok = (bytes_left_ff == 24'd0) && (req_data.frame_length != 24'd0) &&
                     (32'(req_data.stream_index) < NUM_STREAMS);

   always_comb begin
      push          = 1'b0;
      bytes_left_in = bytes_left_ff;
      if (accept) begin
         if (req_data.kind == KIND_FRAME) begin
            if (frame_ok) begin
               push          = 1'b1;
               bytes_left_in = req_data.frame_length;
            end
         end else if (bytes_left_ff != 24'd0) begin
            push          = 1'b1;
            bytes_left_in = bytes_left_ff - 24'd1;
         end
      end
   end

   always_comb begin
      cmd.kind  = req_data.kind;
      cmd.idx   = req_data.stream_index;
      cmd.len   = req_data.frame_length;
      cmd.pts   = req_data.pts;
      cmd.dts   = req_data.dts;
      cmd.video = video_mask_ff[req_data.stream_index];
      cmd.h265  = h265_mask_ff[req_data.stream_index];
      cmd.pcr   = req_data.stream_index == pcr_stream_ff;
      cmd.key   = req_data.is_keyframe;
      cmd.delim = req_data.has_delimiter;
      cmd.data  = req_data.payload_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pid_ff  <= 13'd256;
         pcr_stream_ff <= 3'd0;
         video_mask_ff <= 8'd0;
         h265_mask_ff  <= 8'd0;
         bytes_left_ff <= 24'd0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FIRST_PID:  first_pid_ff  <= csr_data[12:0];
               CSR_PCR_STREAM: pcr_stream_ff <= csr_data[2:0];
               CSR_VIDEO_MASK: video_mask_ff <= csr_data[7:0];
               CSR_H265_MASK:  h265_mask_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: design/ptsp_queue.sv
// ---------------------------------------------------------------------------
// ptsp_queue
// Four-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
module ptsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptsp_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output ptsp_pkg::cmd_type      head_cmd,
   output ptsp_pkg::q_status_type q_status
);
   import ptsp_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, rd_ff;
   logic [AW:0]    count_ff;

   assign q_status.full  = count_ff == (AW+1)'(DEPTH);
   assign q_status.empty = count_ff == '0;
   assign head_cmd       = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: design/ptsp_back.sv
// ---------------------------------------------------------------------------
// ptsp_back
// Byte sequencer: packet heads, pes header, payload, word assembly.
// ---------------------------------------------------------------------------
module ptsp_back #(
   parameter int NUM_STREAMS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptsp_pkg::cmd_type      head_cmd,
   input  ptsp_pkg::q_status_type q_status,
   output logic                   pop,
   input  logic [12:0]            first_pid,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ptsp_pkg::rsp_type      rsp_data
);
   import ptsp_pkg::*;

   localparam int CC_DEPTH = (NUM_STREAMS < 8) ? NUM_STREAMS : 8;
   localparam int CW       = (CC_DEPTH > 1) ? $clog2(CC_DEPTH) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PLAN = 2'd1;
   localparam logic [1:0] S_HEAD = 2'd2;
   localparam logic [1:0] S_PES  = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [2:0]   idx_ff, idx_in;
   logic [23:0]  left_ff, left_in;
   logic         first_ff, first_in;
   logic         pcr_ff, pcr_in;
   logic         rai_ff, rai_in;
   logic [47:0]  pcrv_ff, pcrv_in;
   logic [255:0] hdr_ff, hdr_in;
   logic [4:0]   hlen_ff, hlen_in;
   logic [24:0]  rem_ff, rem_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [7:0]   aft_ff, aft_in;
   logic [12:0]  pid_ff, pid_in;
   logic [3:0]   cc_ff, cc_in;
   logic [3:0]   ccs_ff [CC_DEPTH];
   logic         cc_bump;
   logic [63:0]  asm_ff, asm_in;
   logic [3:0]   fill_ff, fill_in;
   logic [7:0]   pos_ff, pos_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         go, emit;
   logic [7:0]   ebyte;
   logic [63:0]  word_n;
   logic [3:0]   fill1;
   logic [7:0]   pos1;
   logic [7:0]   base, space, stuff;
   logic [4:0]   h_len;
   logic [24:0]  pes_len;
   logic [55:0]  aud;
   logic [95:0]  tail;
   logic [255:0] hdr_new;
   logic         dts_sent, need_aud;
   logic [32:0]  pcr_src;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign go        = !(rsp_valid_ff && rsp_stall);

   // pes header of a new frame, left aligned
   always_comb begin
      dts_sent = head_cmd.pts != head_cmd.dts;
      need_aud = head_cmd.video && !head_cmd.delim;
      aud      = head_cmd.h265 ? 56'h00000001460150 : 56'h0000000109F000;
      h_len    = 5'd14 + (dts_sent ? 5'd5 : 5'd0) +
                 (need_aud ? (head_cmd.h265 ? 5'd7 : 5'd6) : 5'd0);
      pes_len  = {1'b0, head_cmd.len} + 25'(h_len) - 25'd6;
      tail     = dts_sent ? {pes_stamp(4'h1, head_cmd.dts), need_aud ? aud : 56'd0}
                          : {need_aud ? aud : 56'd0, 40'd0};
      hdr_new  = {24'h000001, head_cmd.video ? 8'hE0 : 8'hC0,
                  (!head_cmd.video && pes_len <= 25'h00FFFF) ? pes_len[15:0] : 16'h0000,
                  8'h84, dts_sent ? 8'hC0 : 8'h80, dts_sent ? 8'd10 : 8'd5,
                  pes_stamp(dts_sent ? 4'h3 : 4'h2, head_cmd.pts), tail, 48'd0};
      pcr_src  = (head_cmd.dts != 33'd0) ? head_cmd.dts : head_cmd.pts;
   end

   // packet plan: adaptation field length from the bytes still to carry
   always_comb begin
      base  = pcr_ff ? 8'd8 : (rai_ff ? 8'd2 : 8'd0);
      space = 8'd184 - base;
      stuff = (rem_ff < {17'd0, space}) ? (space - rem_ff[7:0]) : 8'd0;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      first_in = first_ff;
      pcr_in   = pcr_ff;
      rai_in   = rai_ff;
      pcrv_in  = pcrv_ff;
      hdr_in   = hdr_ff;
      hlen_in  = hlen_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      aft_in   = aft_ff;
      pid_in   = pid_ff;
      cc_in    = cc_ff;
      cc_bump  = 1'b0;
      pop      = 1'b0;
      emit     = 1'b0;
      ebyte    = 8'h00;
      if (go) begin
         unique case (state_ff)
            S_IDLE: begin
               if (!q_status.empty) begin
                  if (head_cmd.kind == KIND_FRAME) begin
                     pop      = 1'b1;
                     idx_in   = head_cmd.idx;
                     left_in  = head_cmd.len;
                     first_in = 1'b1;
                     pcr_in   = head_cmd.pcr;
                     rai_in   = head_cmd.video && head_cmd.key;
                     pcrv_in  = {pcr_src, 15'h7E00};
                     hdr_in   = hdr_new;
                     hlen_in  = h_len;
                     rem_in   = {1'b0, head_cmd.len} + 25'(h_len);
                     state_in = S_PLAN;
                  end else if (pos_ff == 8'd0) begin
                     first_in = 1'b0;
                     pcr_in   = 1'b0;
                     rai_in   = 1'b0;
                     rem_in   = {1'b0, left_ff};
                     state_in = S_PLAN;
                  end else begin
                     pop     = 1'b1;
                     emit    = 1'b1;
                     ebyte   = head_cmd.data;
                     left_in = left_ff - 24'd1;
                  end
               end
            end
            S_PLAN: begin
               aft_in   = base + stuff;
               pid_in   = first_pid + 13'(idx_ff);
               cc_in    = ccs_ff[idx_ff[CW-1:0]];
               cc_bump  = 1'b1;
               cnt_in   = 8'd0;
               state_in = S_HEAD;
            end
            S_HEAD: begin
               emit = 1'b1;
               if (cnt_ff == 8'd0)      ebyte = 8'h47;
               else if (cnt_ff == 8'd1) ebyte = {1'b0, first_ff, 1'b0, pid_ff[12:8]};
               else if (cnt_ff == 8'd2) ebyte = pid_ff[7:0];
               else if (cnt_ff == 8'd3) ebyte = {2'b00, aft_ff != 8'd0, 1'b1, cc_ff};
               else if (cnt_ff == 8'd4) ebyte = aft_ff - 8'd1;
               else if (cnt_ff == 8'd5) ebyte = {1'b0, rai_ff, 1'b0, pcr_ff, 4'h0};
               else if (pcr_ff && cnt_ff < 8'd12) begin
                  ebyte   = pcrv_ff[47:40];
                  pcrv_in = {pcrv_ff[39:0], 8'h00};
               end else ebyte = 8'hFF;
               cnt_in = cnt_ff + 8'd1;
               if (cnt_ff == aft_ff + 8'd3) begin
                  cnt_in   = 8'd0;
                  state_in = first_ff ? S_PES : S_IDLE;
               end
            end
            S_PES: begin
               emit   = 1'b1;
               ebyte  = hdr_ff[255:248];
               hdr_in = {hdr_ff[247:0], 8'h00};
               cnt_in = cnt_ff + 8'd1;
               if (cnt_ff[4:0] == hlen_ff - 5'd1) begin
                  first_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   // word assembly
   always_comb begin
      asm_in       = asm_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      word_n       = asm_ff | (64'(ebyte) << (6'd56 - {fill_ff[2:0], 3'b000}));
      fill1        = fill_ff + 4'd1;
      pos1         = pos_ff + 8'd1;
      if (emit) begin
         if (fill1 == 4'd8 || pos1 == 8'(PACKET_BYTES)) begin
            rsp_in.packet_word = word_n;
            rsp_in.byte_count  = fill1;
            rsp_in.packet_end  = pos1 == 8'(PACKET_BYTES);
            rsp_valid_in       = 1'b1;
            asm_in             = 64'd0;
            fill_in            = 4'd0;
            pos_in             = (pos1 == 8'(PACKET_BYTES)) ? 8'd0 : pos1;
         end else begin
            asm_in  = word_n;
            fill_in = fill1;
            pos_in  = pos1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      left_ff <= left_in;
      pcrv_ff <= pcrv_in;
      hdr_ff  <= hdr_in;
      hlen_ff <= hlen_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      aft_ff  <= aft_in;
      pid_ff  <= pid_in;
      cc_ff   <= cc_in;
      rsp_ff  <= rsp_in;
      first_ff <= first_in;
      pcr_ff   <= pcr_in;
      rai_ff   <= rai_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         asm_ff       <= 64'd0;
         fill_ff      <= 4'd0;
         pos_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CC_DEPTH; i++) ccs_ff[i] <= 4'd0;
      end else begin
         state_ff     <= state_in;
         asm_ff       <= asm_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cc_bump) ccs_ff[idx_ff[CW-1:0]] <= cc_in + 4'd1;
      end
   end

endmodule

// File: design/pes_to_ts_packetizer.sv
// ---------------------------------------------------------------------------
// pes_to_ts_packetizer
// Wraps elementary-stream frames into 188-byte transport packets.
// ---------------------------------------------------------------------------
// req_*: one beat per item, a frame-start descriptor followed by its payload
//   bytes. req_stall rises only while the four-entry command queue is full.
// rsp_*: 64-bit packet words, first byte in the top bits, byte_count valid
//   bytes, packet_end on the four-byte word that closes each packet.
// csr_*: register writes, always ready; write only while the block is idle.
// The back end moves at most one packet byte per cycle and none while a word
// waits under rsp_stall; a payload byte goes out straight from the queue head,
// a packet head passes S_PLAN and emits 4..187 head bytes, and a frame start
// adds the 14..26-byte pes header. Payload beats are accepted at one per
// cycle until the queue fills. A beat that completes a word with the back
// end waiting passes the queue and the result register on its way to rsp_*.
// While a word waits under rsp_stall the back end freezes with the word
// held, and the queue absorbs up to four more beats before req_stall rises.
// Reset clears the queue, the continuity counters and the configuration
// registers to their defaults; there is no clearing pass.
module pes_to_ts_packetizer #(
   parameter int NUM_STREAMS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptsp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import ptsp_pkg::*;

   cmd_type      push_cmd, head_cmd;
   q_status_type q_status;
   logic         push, pop;
   logic [12:0]  first_pid;

   ptsp_front #(.NUM_STREAMS(NUM_STREAMS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .push(push), .cmd(push_cmd), .q_status(q_status), .first_pid(first_pid)
   );

   ptsp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_cmd(push_cmd), .pop(pop),
      .head_cmd(head_cmd), .q_status(q_status)
   );

   ptsp_back #(.NUM_STREAMS(NUM_STREAMS)) u_back (
      .clock(clock), .reset(reset),
      .head_cmd(head_cmd), .q_status(q_status), .pop(pop),
      .first_pid(first_pid),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

// File: design/ptsp_checker.sv
// ---------------------------------------------------------------------------
// ptsp_checker
// Port-level checks of the result word stream.
// ---------------------------------------------------------------------------
module ptsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ptsp_pkg::rsp_type rsp_data
);
   import ptsp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_end_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_end |-> rsp_data.byte_count == 4'd4)
      else $error("packet end beat not four bytes");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.packet_end |-> rsp_data.byte_count == 4'd8)
      else $error("mid packet beat not full");

   a_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.packet_end ##1 rsp_valid
      |-> rsp_data.packet_word[63:56] == 8'h47)
      else $error("packet does not start with sync byte");

endmodule

bind pes_to_ts_packetizer ptsp_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
